FILE: design/pknn_pkg.sv
// ----------------------------------------------------------------------------
// pknn_pkg
// Shared types and helpers for the periodic k-nearest-neighbor core.
// ----------------------------------------------------------------------------
package pknn_pkg;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [2:0] REG_BOX_X     = 3'd0;
	localparam logic [2:0] REG_BOX_Y     = 3'd1;
	localparam logic [2:0] REG_BOX_Z     = 3'd2;
	localparam logic [2:0] REG_CUTOFF_SQ = 3'd3;
	localparam logic [2:0] REG_NBR_COUNT = 3'd4;
	localparam logic [2:0] REG_ATOM_CNT  = 3'd5;

	// One stored atom: position, id and species.
	typedef struct packed {
		logic [23:0] x;
		logic [23:0] y;
		logic [23:0] z;
		logic [23:0] id;
		logic [3:0]  typ;
	} atom_t;

	// Tag that travels with each read through the distance pipeline.
	typedef struct packed {
		logic vld;   // slot in flight
		logic emit;  // 1: output rank, 0: scan candidate
		logic ent;   // rank holds a kept atom
		logic last;  // final rank of the query
	} tag_t;

	// Single minimum-image correction on one axis.
	function automatic logic signed [24:0] min_image(logic signed [24:0] d,
		logic [22:0] box);
		logic signed [25:0] d2;
		logic signed [25:0] b2;
		logic signed [24:0] bs;
		begin
			d2 = {d, 1'b0};
			b2 = $signed({3'b000, box});
			bs = $signed({2'b00, box});
			if (d2 > b2) begin
				return d - bs;
			end else if (d2 < -b2) begin
				return d + bs;
			end else begin
				return d;
			end
		end
	endfunction

endpackage

FILE: design/periodic_k_nearest_neighbors_core.sv
// ----------------------------------------------------------------------------
// periodic_k_nearest_neighbors_core
// Top level: atom store, scan sequencer, distance pipeline and best list.
// ----------------------------------------------------------------------------
// A load item (func 0) writes one atom into the store in the cycle it is
// accepted and leaves busy low, so loads may follow back to back. A query item
// (func 1) raises busy: the center atom is read first, then the sequencer
// reads one stored atom per cycle through the single memory read port
// (atom_count atoms, at most MAX_ATOMS), waits for the distance pipeline to
// drain into the sorted best list, and then reads the kept atoms again, one
// rank per cycle, to emit neighbor_count results on consecutive cycles,
// marked by result_valid. Results cannot be stalled: take each item in the
// cycle result_valid is high. Configuration writes take effect at once and
// belong to idle periods.
// ----------------------------------------------------------------------------
module periodic_k_nearest_neighbors_core #(
	parameter int MAX_ATOMS     = 1024,
	parameter int MAX_NEIGHBORS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [9:0]         atom_index,
	input  logic [23:0]        atom_id,
	input  logic [3:0]         atom_type,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [49:0]        cfg_data,
	output logic               result_valid,
	output logic signed [24:0] offset_x,
	output logic signed [24:0] offset_y,
	output logic signed [24:0] offset_z,
	output logic [23:0]        neighbor_id,
	output logic [3:0]         neighbor_type,
	output logic [9:0]         neighbor_slot,
	output logic [49:0]        distance_sq,
	output logic               entry_valid,
	output logic               too_few,
	output logic               last_of_query
);

	localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CW = $clog2(MAX_ATOMS + 1);
	localparam int KW = $clog2(MAX_NEIGHBORS + 1);
	localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	// Shared scan and rank counter: wide enough for either count.
	localparam int QW = (CW > KW) ? CW : KW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CENTER, ST_SCAN, ST_DRAIN, ST_EMIT, ST_FLUSH
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [22:0] box_x_q, box_y_q, box_z_q;
	logic [49:0] cutoff_q;
	logic [5:0]  nbr_cnt_q;
	logic [10:0] atom_cnt_q;

	// Query control
	logic [QW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [KW-1:0] k_q;
	logic          ctr_ok_q;
	logic [23:0]   cx_q, cy_q, cz_q;

	logic [16:0]   idx_ext;
	logic          idx_ok;
	logic [CW-1:0] n_next;
	logic [KW-1:0] k_next;

	pknn_pkg::atom_t wdata, rdata;
	logic [AW-1:0]   raddr;
	logic            mem_we;

	pknn_pkg::tag_t  tag_s1, tag_issue, tag_s4;
	logic [AW-1:0]   slot_s1, slot_issue, slot_s4, rank_slot;
	logic signed [24:0] dx_s4, dy_s4, dz_s4;
	logic [27:0]     idt_s4;
	logic [49:0]     dsq_s4;
	logic            keep_s4, pipe_busy;
	logic [KW-1:0]   filled;
	logic            rank_clear, rank_ins, rank_too_few;
	logic [16:0]     slot_wide;

	assign idx_ext = {7'd0, atom_index};
	assign idx_ok  = idx_ext < 17'(MAX_ATOMS);

	// Clamp the scan length and the rank count to what the hardware holds.
	always_comb begin
		if (17'(atom_cnt_q) > 17'(MAX_ATOMS)) begin
			n_next = CW'(MAX_ATOMS);
		end else begin
			n_next = CW'(atom_cnt_q);
		end
		if (nbr_cnt_q == 6'd0) begin
			k_next = KW'(1);
		end else if (7'(nbr_cnt_q) > 7'(MAX_NEIGHBORS)) begin
			k_next = KW'(MAX_NEIGHBORS);
		end else begin
			k_next = KW'(nbr_cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q    <= 23'd25600;
			box_y_q    <= 23'd25600;
			box_z_q    <= 23'd25600;
			cutoff_q   <= 50'd14745600;
			nbr_cnt_q  <= 6'd12;
			atom_cnt_q <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				pknn_pkg::REG_BOX_X:     box_x_q    <= cfg_data[22:0];
				pknn_pkg::REG_BOX_Y:     box_y_q    <= cfg_data[22:0];
				pknn_pkg::REG_BOX_Z:     box_z_q    <= cfg_data[22:0];
				pknn_pkg::REG_CUTOFF_SQ: cutoff_q   <= cfg_data;
				pknn_pkg::REG_NBR_COUNT: nbr_cnt_q  <= cfg_data[5:0];
				pknn_pkg::REG_ATOM_CNT:  atom_cnt_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Store a loaded atom straight away; drop loads beyond the store.
	assign mem_we = start && !busy && (func == pknn_pkg::FUNC_LOAD) && idx_ok;
	assign wdata  = '{x: pos_x, y: pos_y, z: pos_z, id: atom_id, typ: atom_type};

	// Read address: center at accept, scan slots, then the ranked slots.
	always_comb begin
		case (state_q)
			ST_SCAN: raddr = cnt_q[AW-1:0];
			ST_EMIT: raddr = rank_slot;
			default: raddr = idx_ext[AW-1:0];
		endcase
	end

	pknn_mem #(.DEPTH(MAX_ATOMS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_ext[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Tag the read issued this cycle.
	always_comb begin
		tag_issue      = '0;
		tag_issue.vld  = (state_q == ST_SCAN) || (state_q == ST_EMIT);
		tag_issue.emit = state_q == ST_EMIT;
		tag_issue.ent  = cnt_q < QW'(filled);
		tag_issue.last = cnt_q == QW'(k_q - KW'(1));
		slot_issue     = (state_q == ST_EMIT) ? rank_slot : cnt_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_issue;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= slot_issue;
	end

	pknn_dist #(.SW(AW)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.atom_s1   (rdata),
		.slot_s1   (slot_s1),
		.cx        (cx_q),
		.cy        (cy_q),
		.cz        (cz_q),
		.box_x     (box_x_q),
		.box_y     (box_y_q),
		.box_z     (box_z_q),
		.cutoff_sq (cutoff_q),
		.tag_s4    (tag_s4),
		.dx_s4     (dx_s4),
		.dy_s4     (dy_s4),
		.dz_s4     (dz_s4),
		.idt_s4    (idt_s4),
		.slot_s4   (slot_s4),
		.dsq_s4    (dsq_s4),
		.keep_s4   (keep_s4),
		.pipe_busy (pipe_busy)
	);

	assign rank_clear = state_q == ST_CENTER;
	assign rank_ins   = tag_s4.vld && !tag_s4.emit && keep_s4;

	pknn_rank #(
		.DEPTH (MAX_NEIGHBORS),
		.SW    (AW),
		.KW    (KW),
		.IW    (IW),
		.CW    (CW)
	) u_rank (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (rank_clear),
		.ins     (rank_ins),
		.dsq     (dsq_s4),
		.slot    (slot_s4),
		.k       (k_q),
		.rd_idx  (cnt_q[IW-1:0]),
		.rd_slot (rank_slot),
		.filled  (filled),
		.too_few (rank_too_few)
	);

	// Sequencer: center read, scan, drain, emit ranks, flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			n_q      <= '0;
			k_q      <= KW'(1);
			ctr_ok_q <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && (func == pknn_pkg::FUNC_QUERY)) begin
						n_q      <= n_next;
						k_q      <= k_next;
						ctr_ok_q <= idx_ok;
						state_q  <= ST_CENTER;
					end
				end
				ST_CENTER: begin
					// Out-of-range center sits at the origin.
					cx_q    <= ctr_ok_q ? rdata.x : 24'd0;
					cy_q    <= ctr_ok_q ? rdata.y : 24'd0;
					cz_q    <= ctr_ok_q ? rdata.z : 24'd0;
					cnt_q   <= '0;
					state_q <= (n_q == '0) ? ST_DRAIN : ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + QW'(1);
					if (cnt_q == QW'(n_q - CW'(1))) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					cnt_q <= cnt_q + QW'(1);
					if (cnt_q == QW'(k_q - KW'(1))) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;

	// Missing ranks come out with all payload fields zero.
	assign slot_wide     = 17'(slot_s4);
	assign result_valid  = tag_s4.vld && tag_s4.emit;
	assign entry_valid   = tag_s4.ent;
	assign offset_x      = tag_s4.ent ? dx_s4 : '0;
	assign offset_y      = tag_s4.ent ? dy_s4 : '0;
	assign offset_z      = tag_s4.ent ? dz_s4 : '0;
	assign neighbor_id   = tag_s4.ent ? idt_s4[27:4] : '0;
	assign neighbor_type = tag_s4.ent ? idt_s4[3:0] : '0;
	assign neighbor_slot = tag_s4.ent ? slot_wide[9:0] : '0;
	assign distance_sq   = tag_s4.ent ? dsq_s4 : '0;
	assign too_few       = rank_too_few;
	assign last_of_query = tag_s4.last;

endmodule

FILE: design/pknn_mem.sv
// ----------------------------------------------------------------------------
// pknn_mem
// Atom store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pknn_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  pknn_pkg::atom_t   wdata,
	input  logic [AW-1:0]     raddr,
	output pknn_pkg::atom_t   rdata
);

	pknn_pkg::atom_t mem [DEPTH];
	pknn_pkg::atom_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/pknn_dist.sv
// ----------------------------------------------------------------------------
// pknn_dist
// Displacement pipeline: minimum image, squares, sum and cutoff test.
// ----------------------------------------------------------------------------
module pknn_dist #(
	parameter int SW = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pknn_pkg::tag_t      tag_s1,
	input  pknn_pkg::atom_t     atom_s1,
	input  logic [SW-1:0]       slot_s1,
	input  logic [23:0]         cx,
	input  logic [23:0]         cy,
	input  logic [23:0]         cz,
	input  logic [22:0]         box_x,
	input  logic [22:0]         box_y,
	input  logic [22:0]         box_z,
	input  logic [49:0]         cutoff_sq,
	output pknn_pkg::tag_t      tag_s4,
	output logic signed [24:0]  dx_s4,
	output logic signed [24:0]  dy_s4,
	output logic signed [24:0]  dz_s4,
	output logic [27:0]         idt_s4,
	output logic [SW-1:0]       slot_s4,
	output logic [49:0]         dsq_s4,
	output logic                keep_s4,
	output logic                pipe_busy
);

	pknn_pkg::tag_t     tag_s2, tag_s3, tag_q4;
	logic signed [24:0] dx_s2, dy_s2, dz_s2, dx_s3, dy_s3, dz_s3, dx_q4, dy_q4, dz_q4;
	logic [27:0]        idt_s2, idt_s3, idt_q4;
	logic [SW-1:0]      slot_s2, slot_s3, slot_q4;
	logic signed [49:0] px, py, pz;
	logic [49:0]        sx_s3, sy_s3, sz_s3, sum, dsq_q4;
	logic               keep_q4;

	assign px  = dx_s2 * dx_s2;
	assign py  = dy_s2 * dy_s2;
	assign pz  = dz_s2 * dz_s2;
	assign sum = sx_s3 + sy_s3 + sz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_q4 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_q4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2   <= pknn_pkg::min_image($signed({atom_s1.x[23], atom_s1.x}) -
			$signed({cx[23], cx}), box_x);
		dy_s2   <= pknn_pkg::min_image($signed({atom_s1.y[23], atom_s1.y}) -
			$signed({cy[23], cy}), box_y);
		dz_s2   <= pknn_pkg::min_image($signed({atom_s1.z[23], atom_s1.z}) -
			$signed({cz[23], cz}), box_z);
		idt_s2  <= {atom_s1.id, atom_s1.typ};
		slot_s2 <= slot_s1;
		sx_s3   <= $unsigned(px);
		sy_s3   <= $unsigned(py);
		sz_s3   <= $unsigned(pz);
		dx_s3   <= dx_s2;
		dy_s3   <= dy_s2;
		dz_s3   <= dz_s2;
		idt_s3  <= idt_s2;
		slot_s3 <= slot_s2;
		dsq_q4  <= sum;
		keep_q4 <= sum < cutoff_sq;
		dx_q4   <= dx_s3;
		dy_q4   <= dy_s3;
		dz_q4   <= dz_s3;
		idt_q4  <= idt_s3;
		slot_q4 <= slot_s3;
	end

	assign tag_s4    = tag_q4;
	assign dx_s4     = dx_q4;
	assign dy_s4     = dy_q4;
	assign dz_s4     = dz_q4;
	assign idt_s4    = idt_q4;
	assign slot_s4   = slot_q4;
	assign dsq_s4    = dsq_q4;
	assign keep_s4   = keep_q4;
	assign pipe_busy = tag_s1.vld | tag_s2.vld | tag_s3.vld | tag_q4.vld;

endmodule

FILE: design/pknn_rank.sv
// ----------------------------------------------------------------------------
// pknn_rank
// Sorted best list: a row of cells that shift to open a slot on insert.
// ----------------------------------------------------------------------------
module pknn_rank #(
	parameter int DEPTH = 32,
	parameter int SW    = 10,
	parameter int KW    = 6,
	parameter int IW    = 5,
	parameter int CW    = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             ins,
	input  logic [49:0]      dsq,
	input  logic [SW-1:0]    slot,
	input  logic [KW-1:0]    k,
	input  logic [IW-1:0]    rd_idx,
	output logic [SW-1:0]    rd_slot,
	output logic [KW-1:0]    filled,
	output logic             too_few
);

	logic [49:0]   dist_q [DEPTH];
	logic [SW-1:0] slot_q [DEPTH];
	logic [KW-1:0] filled_q;
	logic [CW-1:0] within_q;
	logic [DEPTH-1:0] gt;

	// An entry yields when it is empty or holds a larger distance.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (KW'(i) < k) && ((KW'(i) >= filled_q) || (dist_q[i] > dsq));
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ins && gt[i]) begin
				if (i == 0) begin
					dist_q[i] <= dsq;
					slot_q[i] <= slot;
				end else if (!gt[(i > 0) ? i - 1 : 0]) begin
					dist_q[i] <= dsq;
					slot_q[i] <= slot;
				end else begin
					dist_q[i] <= dist_q[(i > 0) ? i - 1 : 0];
					slot_q[i] <= slot_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			within_q <= '0;
		end else if (clear) begin
			filled_q <= '0;
			within_q <= '0;
		end else if (ins) begin
			within_q <= within_q + CW'(1);
			if ((|gt) && (filled_q < k)) begin
				filled_q <= filled_q + KW'(1);
			end
		end
	end

	assign rd_slot = slot_q[rd_idx];
	assign filled  = filled_q;
	assign too_few = within_q < CW'(k);

endmodule

FILE: design/pknn_chk.sv
// ----------------------------------------------------------------------------
// pknn_chk
// Port-level checks on the core's query and result behavior.
// ----------------------------------------------------------------------------
module pknn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        func,
	input logic        result_valid,
	input logic        entry_valid,
	input logic        too_few,
	input logic        last_of_query,
	input logic [49:0] distance_sq
);

	a_result_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside a query");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func) |=> busy)
		else $error("query did not raise busy");

	a_ranks_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_query) |=> result_valid)
		else $error("gap between ranks");

	a_missing_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !entry_valid) |-> (too_few && distance_sq == 50'd0))
		else $error("missing rank without too_few");

endmodule

bind periodic_k_nearest_neighbors_core pknn_chk u_pknn_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.func          (func),
	.result_valid  (result_valid),
	.entry_valid   (entry_valid),
	.too_few       (too_few),
	.last_of_query (last_of_query),
	.distance_sq   (distance_sq)
);
